>>> hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CHK_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/grc_pkg.sv
package grc_pkg;

	localparam int DIM_W     = 7;
	localparam int CHAR_W    = 8;
	localparam int COUNT_W   = 12;
	localparam int CFG_IDX_W = 1;

	localparam logic [CHAR_W-1:0]  WALL_CHAR = 8'd35;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
	localparam logic [DIM_W-1:0]   DIM_RESET = 7'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_CLEAR    = 8'b0000_0010,
		ST_SCAN_RD  = 8'b0000_0100,
		ST_SCAN_CHK = 8'b0000_1000,
		ST_POP      = 8'b0001_0000,
		ST_NBR      = 8'b0010_0000,
		ST_DRAIN    = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		NB_DOWN  = 2'd0,
		NB_UP    = 2'd1,
		NB_RIGHT = 2'd2,
		NB_LEFT  = 2'd3
	} nbr_t;

	typedef struct packed {
		logic rd_en;
		logic wall_we;
		logic wall_d;
		logic vis_we;
		logic vis_d;
	} cell_ctl_t;

	typedef struct packed {
		logic flush;
		logic push;
		logic pop;
	} queue_ctl_t;

endpackage

>>> hdl/grc_cell_mem.sv
module grc_cell_mem #(
	parameter int CELLS = 4096,
	parameter int AW    = 12
) (
	input  logic               clk,
	input  grc_pkg::cell_ctl_t ctl,
	input  logic [AW-1:0]      rd_addr,
	input  logic [AW-1:0]      wr_addr,
	output logic               rd_wall,
	output logic               rd_vis
);

	logic wall_mem [CELLS];
	logic vis_mem  [CELLS];
	logic wall_q;
	logic vis_q;

	always_ff @(posedge clk) begin
		if (ctl.wall_we) begin
			wall_mem[wr_addr] <= ctl.wall_d;
		end
		if (ctl.rd_en) begin
			wall_q <= wall_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vis_we) begin
			vis_mem[wr_addr] <= ctl.vis_d;
		end
		if (ctl.rd_en) begin
			vis_q <= vis_mem[rd_addr];
		end
	end

	assign rd_wall = wall_q;
	assign rd_vis  = vis_q;

endmodule

>>> hdl/grc_queue.sv
module grc_queue #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int CW    = 13,
	parameter int DW    = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  grc_pkg::queue_ctl_t ctl,
	input  logic [DW-1:0]       wr_data,
	output logic [DW-1:0]       rd_data,
	output logic                empty
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;
	logic [CW-1:0] head_q;
	logic [CW-1:0] tail_q;
	logic [CW-1:0] wr_ptr;
	logic [CW-1:0] head_base;

	// flush restarts the queue; a push in the same cycle lands in entry zero
	assign wr_ptr    = ctl.flush ? '0 : tail_q;
	assign head_base = ctl.flush ? '0 : head_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_ptr[AW-1:0]] <= wr_data;
		end
		if (ctl.pop) begin
			rd_q <= mem[head_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			head_q <= head_base + CW'(ctl.pop);
			tail_q <= wr_ptr + CW'(ctl.push);
		end
	end

	assign rd_data = rd_q;
	assign empty   = (head_q == tail_q);

endmodule

>>> hdl/grid_room_counter.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------
// input     | in_valid / in_stall  | cell_char, last_cell
// output    | out_valid / out_stall| room_count
// config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Cells load at one per cycle into the wall map. The last cell starts a count:
// a pass that clears the visited map over all rows*cols cells, then a raster
// scan that reads and checks each cell, and for each floor cell a queue pop
// plus four neighbor read/check slots on the single cell-memory read port.
// in_stall is high from the last cell until the result sits in the output
// register; a stalled result holds, and the next grid may load behind it.
// arst_n clears control state; grid_rows and grid_cols reset to 64.
module grid_room_counter #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [grc_pkg::CHAR_W-1:0]      cell_char,
	input  logic                            last_cell,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [grc_pkg::COUNT_W-1:0]     room_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [grc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [grc_pkg::DIM_W-1:0]       cfg_data
);

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int PW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW    = $clog2(CELLS + 1);
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CLW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int MW    = (RW > CLW) ? RW : CLW;
	localparam int EW    = ((MW > grc_pkg::DIM_W) ? MW : grc_pkg::DIM_W) + 1;
	localparam int QW    = RW + CLW + PW;
	localparam int DW    = grc_pkg::DIM_W;

	grc_pkg::state_t     state_q, state_d;
	logic [DW-1:0]       rows_q, cols_q;
	logic [DW-1:0]       rows_eff, cols_eff;
	logic [2*DW-1:0]     area;
	logic [CW-1:0]       total;
	logic [CW-1:0]       load_idx_q;
	logic [PW-1:0]       clr_q;
	logic [PW-1:0]       scan_p_q;
	logic [RW-1:0]       scan_r_q;
	logic [CLW-1:0]      scan_c_q;
	logic [grc_pkg::COUNT_W-1:0] region_q;
	logic [grc_pkg::COUNT_W-1:0] room_q;
	logic                out_valid_q;
	grc_pkg::nbr_t       nb_q;
	logic                chk_v_s1;
	logic [PW-1:0]       chk_p_s1;
	logic [RW-1:0]       chk_r_s1;
	logic [CLW-1:0]      chk_c_s1;

	logic                in_fire;
	logic                load_ok;
	logic                scan_last, clr_last, col_last;
	logic                scan_adv, seed, push_chk, out_free;
	logic [RW-1:0]       cur_r, nb_r;
	logic [CLW-1:0]      cur_c, nb_c;
	logic [PW-1:0]       cur_p, nb_p;
	logic                nb_ok;

	grc_pkg::cell_ctl_t  cell_ctl;
	logic [PW-1:0]       cell_rd_addr, cell_wr_addr;
	logic                rd_wall, rd_vis;
	grc_pkg::queue_ctl_t q_ctl;
	logic [QW-1:0]       q_wr_data, q_rd_data;
	logic                q_empty;

	// zero means one, anything past the array size saturates
	always_comb begin
		if (rows_q == '0) begin
			rows_eff = DW'(1);
		end else if (EW'(rows_q) > EW'(MAX_ROWS)) begin
			rows_eff = DW'(MAX_ROWS);
		end else begin
			rows_eff = rows_q;
		end
		if (cols_q == '0) begin
			cols_eff = DW'(1);
		end else if (EW'(cols_q) > EW'(MAX_COLS)) begin
			cols_eff = DW'(MAX_COLS);
		end else begin
			cols_eff = cols_q;
		end
	end

	assign area      = {{DW{1'b0}}, rows_eff} * {{DW{1'b0}}, cols_eff};
	assign total     = CW'(area);
	assign load_ok   = (load_idx_q < total);
	assign scan_last = ((CW'(scan_p_q) + CW'(1)) == total);
	assign clr_last  = ((CW'(clr_q) + CW'(1)) == total);
	assign col_last  = ((EW'(scan_c_q) + EW'(1)) == EW'(cols_eff));
	assign in_fire   = in_valid && (state_q == grc_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// queue entry layout: {row, col, position}
	assign cur_r = q_rd_data[QW-1 -: RW];
	assign cur_c = q_rd_data[PW+CLW-1 -: CLW];
	assign cur_p = q_rd_data[PW-1:0];

	always_comb begin
		nb_ok = 1'b0;
		nb_r  = cur_r;
		nb_c  = cur_c;
		nb_p  = cur_p;
		case (nb_q)
			grc_pkg::NB_DOWN: begin
				nb_ok = (EW'(cur_r) + EW'(1)) < EW'(rows_eff);
				nb_r  = RW'(cur_r + 1'b1);
				nb_p  = PW'(CW'(cur_p) + CW'(cols_eff));
			end
			grc_pkg::NB_UP: begin
				nb_ok = (cur_r != '0);
				nb_r  = RW'(cur_r - 1'b1);
				nb_p  = PW'(CW'(cur_p) - CW'(cols_eff));
			end
			grc_pkg::NB_RIGHT: begin
				nb_ok = (EW'(cur_c) + EW'(1)) < EW'(cols_eff);
				nb_c  = CLW'(cur_c + 1'b1);
				nb_p  = PW'(cur_p + 1'b1);
			end
			grc_pkg::NB_LEFT: begin
				nb_ok = (cur_c != '0);
				nb_c  = CLW'(cur_c - 1'b1);
				nb_p  = PW'(cur_p - 1'b1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d      = state_q;
		cell_ctl     = '0;
		cell_rd_addr = scan_p_q;
		cell_wr_addr = load_idx_q[PW-1:0];
		q_ctl        = '0;
		q_wr_data    = {scan_r_q, scan_c_q, scan_p_q};
		seed         = 1'b0;
		scan_adv     = 1'b0;
		push_chk     = 1'b0;

		// check slot: neighbor read in the cycle before
		if (chk_v_s1 && !rd_wall && !rd_vis) begin
			push_chk        = 1'b1;
			cell_ctl.vis_we = 1'b1;
			cell_ctl.vis_d  = 1'b1;
			cell_wr_addr    = chk_p_s1;
			q_ctl.push      = 1'b1;
			q_wr_data       = {chk_r_s1, chk_c_s1, chk_p_s1};
		end

		case (state_q)
			grc_pkg::ST_IDLE: begin
				if (in_fire) begin
					cell_ctl.wall_we = load_ok;
					cell_ctl.wall_d  = (cell_char == grc_pkg::WALL_CHAR);
					if (last_cell) begin
						state_d = grc_pkg::ST_CLEAR;
					end
				end
			end
			grc_pkg::ST_CLEAR: begin
				cell_ctl.vis_we = 1'b1;
				cell_ctl.vis_d  = 1'b0;
				cell_wr_addr    = clr_q;
				if (clr_last) begin
					state_d = grc_pkg::ST_SCAN_RD;
				end
			end
			grc_pkg::ST_SCAN_RD: begin
				cell_ctl.rd_en = 1'b1;
				state_d        = grc_pkg::ST_SCAN_CHK;
			end
			grc_pkg::ST_SCAN_CHK: begin
				if (!rd_wall && !rd_vis) begin
					seed            = 1'b1;
					cell_ctl.vis_we = 1'b1;
					cell_ctl.vis_d  = 1'b1;
					cell_wr_addr    = scan_p_q;
					q_ctl.flush     = 1'b1;
					q_ctl.push      = 1'b1;
					state_d         = grc_pkg::ST_POP;
				end else begin
					scan_adv = 1'b1;
				end
			end
			grc_pkg::ST_POP: begin
				q_ctl.pop = 1'b1;
				state_d   = grc_pkg::ST_NBR;
			end
			grc_pkg::ST_NBR: begin
				cell_ctl.rd_en = nb_ok;
				cell_rd_addr   = nb_p;
				if (nb_q == grc_pkg::NB_LEFT) begin
					state_d = grc_pkg::ST_DRAIN;
				end
			end
			grc_pkg::ST_DRAIN: begin
				if (q_empty && !push_chk) begin
					scan_adv = 1'b1;
				end else begin
					state_d = grc_pkg::ST_POP;
				end
			end
			grc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = grc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = grc_pkg::ST_IDLE;
			end
		endcase

		if (scan_adv) begin
			state_d = scan_last ? grc_pkg::ST_DONE : grc_pkg::ST_SCAN_RD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= grc_pkg::ST_IDLE;
			rows_q      <= grc_pkg::DIM_RESET;
			cols_q      <= grc_pkg::DIM_RESET;
			load_idx_q  <= '0;
			clr_q       <= '0;
			scan_p_q    <= '0;
			scan_r_q    <= '0;
			scan_c_q    <= '0;
			region_q    <= '0;
			out_valid_q <= 1'b0;
			nb_q        <= grc_pkg::NB_DOWN;
			chk_v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid) begin
				case (grc_pkg::cfg_reg_t'(cfg_index))
					grc_pkg::REG_GRID_ROWS: rows_q <= cfg_data;
					grc_pkg::REG_GRID_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_fire) begin
				if (load_ok) begin
					load_idx_q <= load_idx_q + CW'(1);
				end
				if (last_cell) begin
					load_idx_q <= '0;
					clr_q      <= '0;
					scan_p_q   <= '0;
					scan_r_q   <= '0;
					scan_c_q   <= '0;
					region_q   <= '0;
				end
			end

			if (state_q == grc_pkg::ST_CLEAR) begin
				clr_q <= PW'(clr_q + 1'b1);
			end

			if (seed && (region_q != grc_pkg::COUNT_MAX)) begin
				region_q <= region_q + 1'b1;
			end

			if (scan_adv && !scan_last) begin
				scan_p_q <= PW'(scan_p_q + 1'b1);
				if (col_last) begin
					scan_c_q <= '0;
					scan_r_q <= RW'(scan_r_q + 1'b1);
				end else begin
					scan_c_q <= CLW'(scan_c_q + 1'b1);
				end
			end

			if (state_q == grc_pkg::ST_POP) begin
				nb_q <= grc_pkg::NB_DOWN;
			end else if (state_q == grc_pkg::ST_NBR) begin
				nb_q <= grc_pkg::nbr_t'(nb_q + 2'd1);
			end
			chk_v_s1 <= (state_q == grc_pkg::ST_NBR) && nb_ok;

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == grc_pkg::ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_p_s1 <= nb_p;
		chk_r_s1 <= nb_r;
		chk_c_s1 <= nb_c;
		if ((state_q == grc_pkg::ST_DONE) && out_free) begin
			room_q <= region_q;
		end
	end

	grc_cell_mem #(
		.CELLS (CELLS),
		.AW    (PW)
	) u_cell_mem (
		.clk     (clk),
		.ctl     (cell_ctl),
		.rd_addr (cell_rd_addr),
		.wr_addr (cell_wr_addr),
		.rd_wall (rd_wall),
		.rd_vis  (rd_vis)
	);

	grc_queue #(
		.DEPTH (CELLS),
		.AW    (PW),
		.CW    (CW),
		.DW    (QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (q_ctl),
		.wr_data (q_wr_data),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	assign in_stall   = (state_q != grc_pkg::ST_IDLE);
	assign out_valid  = out_valid_q;
	assign room_count = room_q;
	assign cfg_ready  = 1'b1;

endmodule

>>> hdl/grc_checker.sv
`include "assert_macros.svh"

module grc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        last_cell,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [grc_pkg::COUNT_W-1:0] room_count
);

	// the last cell starts a count, which holds off further cells
	`CHK_NEXT(a_last_stalls, in_valid && !in_stall && last_cell, in_stall, "no stall after last cell")

	// ordinary cells load back to back
	`CHK_NEXT(a_cell_streams, in_valid && !in_stall && !last_cell, !in_stall, "stall after plain cell")

	// a new result only appears at the end of a busy count
	`CHK_IMPLY(a_result_after_count, $rose(out_valid), $past(in_stall), "result without a count")

	`CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(room_count), "stalled result moved")

endmodule

bind grid_room_counter grc_checker u_grc_checker (.*);
